FILE: src/assert_macros.svh
// Assertion helpers, clocked on clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define FRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define FRE_ASSERT_NEVER(lbl, expr, msg) \
  `FRE_ASSERT(lbl, !(expr), msg)

`endif

FILE: src/fre_pkg.sv
package fre_pkg;

  localparam int NUM_SOURCES = 4;
  localparam int SRC_W = 2;
  localparam int MAX_FRAME = 65536;
  localparam int FRAME_AW = 16;
  localparam int PART_SIZE = 1024;
  localparam int PART_OW = 10;
  localparam int PARTS_PER_SLOT = MAX_FRAME / PART_SIZE;
  localparam int PART_IW = FRAME_AW - PART_OW;
  localparam int PCNT_W = 11;
  localparam int ROW_W = 64;
  localparam int ROW_OW = 6;
  localparam int ROW_IW = FRAME_AW - ROW_OW;
  localparam int HDR_BASE = 32;
  localparam int HEADER_SIZE = 48;
  localparam int POS_W = 17;
  localparam int CNT_W = 17;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef enum logic [1:0] {
    MODE_BYTE  = 2'd0,
    MODE_RESET = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    RK_DROPPED   = 3'd0,
    RK_STORED    = 3'd1,
    RK_COMPLETED = 3'd2,
    RK_ACK       = 3'd3,
    RK_READ      = 3'd4
  } res_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_STORE_RD,
    S_STORE_WR,
    S_REPORT,
    S_QUERY,
    S_READ,
    S_READ_OUT
  } state_t;

  typedef struct packed {
    logic                              frame_we;
    logic [SRC_W+FRAME_AW-1:0]         frame_addr;
    logic [7:0]                        frame_wdata;
    logic                              seen_we;
    logic [SRC_W+ROW_IW-1:0]           seen_waddr;
    logic [SRC_W+ROW_IW-1:0]           seen_raddr;
    logic [ROW_W-1:0]                  seen_wdata;
    logic                              part_we;
    logic [SRC_W+PART_IW-1:0]          part_waddr;
    logic [SRC_W+PART_IW-1:0]          part_raddr;
    logic [PCNT_W-1:0]                 part_wdata;
  } mem_cmd_t;

  typedef struct packed {
    logic [7:0]        frame_rdata;
    logic [ROW_W-1:0]  seen_rdata;
    logic [PCNT_W-1:0] part_rdata;
  } mem_rsp_t;

endpackage

FILE: src/fre_mem.sv
module fre_mem (
  input  logic              clk,
  input  fre_pkg::mem_cmd_t cmd,
  output fre_pkg::mem_rsp_t rsp
);
  import fre_pkg::*;

  logic [7:0]        frame_mem [NUM_SOURCES*MAX_FRAME];
  logic [ROW_W-1:0]  seen_mem  [NUM_SOURCES*(MAX_FRAME/ROW_W)];
  logic [PCNT_W-1:0] part_mem  [NUM_SOURCES*PARTS_PER_SLOT];

  always_ff @(posedge clk) begin
    if (cmd.frame_we) begin
      frame_mem[cmd.frame_addr] <= cmd.frame_wdata;
    end
    rsp.frame_rdata <= frame_mem[cmd.frame_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.seen_we) begin
      seen_mem[cmd.seen_waddr] <= cmd.seen_wdata;
    end
    rsp.seen_rdata <= seen_mem[cmd.seen_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.part_we) begin
      part_mem[cmd.part_waddr] <= cmd.part_wdata;
    end
    rsp.part_rdata <= part_mem[cmd.part_raddr];
  end

endmodule

FILE: src/fragment_reassembly_engine.sv
// Channel | Ports      | Contents
// in      | in_t*      | tuser mode, tlast end_of_packet, tdata source/byte/query/address
// out     | out_t*     | tuser result_kind, tdata frame info, mask, read data
// Header and rejected bytes are taken in the idle state alone. Stored byte: seen-row
// and part-count read-modify-write. First byte of a new frame first clears
// the slot's seen rows and part counts. Query of an active frame: a sweep
// over the part-count memory. Read: one frame-memory read. End report adds a state.
// Synchronous active-low reset clears control; no memory clearing pass.
// A new item is taken only when the block is idle and the result slot is empty.
module fragment_reassembly_engine (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [1:0] source, [9:2] data_byte, [41:10] query_sequence, [57:42] read_address
  input  logic [63:0]  in_tdata,
  // [1:0] mode
  input  logic [1:0]   in_tuser,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] sequence, [48:32] frame_total, [65:49] bytes_received, [66] known,
  // [67] complete, [131:68] missing_mask, [139:132] read_data
  output logic [143:0] out_tdata,
  // [2:0] result_kind
  output logic [2:0]   out_tuser
);
  import fre_pkg::*;
  `include "assert_macros.svh"

  state_t state_r, state_nxt;
  mem_cmd_t cmd;
  mem_rsp_t rsp;

  logic [POS_W-1:0]    pos_r;
  logic [31:0]         hdr_r [4];
  logic                stored_r;
  logic [SRC_W-1:0]    s_r;
  logic                eop_r;
  logic [7:0]          byte_r;
  logic [FRAME_AW-1:0] spos_r;
  logic [31:0]         q_r;
  logic [ROW_IW-1:0]   clr_r;
  logic [PART_IW:0]    qk_r;
  logic                qd_r;
  logic [PART_IW-1:0]  qi_r;
  logic [63:0]         mask_r;

  logic                act_r  [NUM_SOURCES];
  logic [31:0]         aseq_r [NUM_SOURCES];
  logic [CNT_W-1:0]    atot_r [NUM_SOURCES];
  logic [CNT_W-1:0]    rcv_r  [NUM_SOURCES];
  logic                cval_r [NUM_SOURCES];
  logic [31:0]         cseq_r [NUM_SOURCES];

  logic                out_valid_r;
  res_kind_t           o_kind_r;
  logic [31:0]         o_seq_r;
  logic [CNT_W-1:0]    o_tot_r;
  logic [CNT_W-1:0]    o_rcv_r;
  logic                o_known_r;
  logic                o_comp_r;
  logic [63:0]         o_mask_r;
  logic [7:0]          o_rd_r;

  mode_t               in_mode;
  logic [SRC_W-1:0]    in_src;
  logic [7:0]          in_byte;
  logic [31:0]         in_q;
  logic [FRAME_AW-1:0] in_addr;
  logic                acc;

  assign in_mode = mode_t'(in_tuser);
  assign in_src  = in_tdata[1:0];
  assign in_byte = in_tdata[9:2];
  assign in_q    = in_tdata[41:10];
  assign in_addr = in_tdata[57:42];
  assign in_tready = (state_r == S_IDLE) && !out_valid_r;
  assign acc = in_tvalid && in_tready;

  // payload check for the byte at the current packet position
  logic [31:0]         h_seq, h_tot, h_off, h_len, p_i;
  logic                is_hdr, do_store, new_frame;
  logic [FRAME_AW-1:0] st_pos;
  assign h_seq = hdr_r[0];
  assign h_tot = hdr_r[1];
  assign h_off = hdr_r[2];
  assign h_len = hdr_r[3];
  assign p_i   = 32'(pos_r) - 32'(HEADER_SIZE);
  assign is_hdr = (pos_r >= POS_W'(HDR_BASE)) && (pos_r < POS_W'(HEADER_SIZE));
  assign do_store = (pos_r >= POS_W'(HEADER_SIZE)) && (h_tot != 32'd0)
                 && (h_tot <= 32'(MAX_FRAME)) && (h_len != 32'd0) && (h_off < h_tot)
                 && (p_i < h_len) && (p_i < (h_tot - h_off));
  assign st_pos = h_off[FRAME_AW-1:0] + p_i[FRAME_AW-1:0];
  assign new_frame = !act_r[in_src] || (aseq_r[in_src] != h_seq)
                  || (atot_r[in_src] != h_tot[CNT_W-1:0]);

  logic cmp_done;
  assign cmp_done = cval_r[in_src] && (cseq_r[in_src] == in_q);
  logic act_hit;
  assign act_hit = act_r[in_src] && (aseq_r[in_src] == in_q);

  // store read-modify-write
  logic             seen_bit;
  logic [ROW_W-1:0] seen_set;
  assign seen_bit = rsp.seen_rdata[spos_r[ROW_OW-1:0]];
  assign seen_set = rsp.seen_rdata | (ROW_W'(1) << spos_r[ROW_OW-1:0]);

  // query sweep
  logic [CNT_W-1:0] q_tot, q_base, q_rem;
  logic             q_bit;
  logic [63:0]      mask_nxt;
  assign q_tot  = atot_r[s_r];
  assign q_base = {1'b0, qi_r, {PART_OW{1'b0}}};
  assign q_rem  = q_tot - q_base;
  assign q_bit  = (q_base < q_tot) && (rsp.part_rdata < PCNT_W'(PART_SIZE))
               && (CNT_W'(rsp.part_rdata) < q_rem);
  assign mask_nxt = mask_r | (qd_r && q_bit ? (64'd1 << qi_r) : 64'd0);

  logic rep_done;
  assign rep_done = act_r[s_r] && (rcv_r[s_r] >= atot_r[s_r]);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_mode)
            MODE_BYTE: begin
              if (!is_hdr && do_store) begin
                state_nxt = new_frame ? S_CLEAR : S_STORE_RD;
              end else if (in_tlast) begin
                state_nxt = S_REPORT;
              end
            end
            MODE_QUERY: begin
              if (!cmp_done && act_hit) begin
                state_nxt = S_QUERY;
              end
            end
            MODE_READ: state_nxt = S_READ;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLEAR:    if (clr_r == '1) state_nxt = S_STORE_RD;
      S_STORE_RD: state_nxt = S_STORE_WR;
      S_STORE_WR: state_nxt = eop_r ? S_REPORT : S_IDLE;
      S_REPORT:   state_nxt = S_IDLE;
      S_QUERY:    if (qd_r && qi_r == '1) state_nxt = S_IDLE;
      S_READ:     state_nxt = S_READ_OUT;
      S_READ_OUT: state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.frame_addr = {s_r, spos_r};
    cmd.frame_wdata = byte_r;
    cmd.seen_waddr = {s_r, spos_r[FRAME_AW-1:ROW_OW]};
    cmd.seen_raddr = {s_r, spos_r[FRAME_AW-1:ROW_OW]};
    cmd.seen_wdata = seen_set;
    cmd.part_waddr = {s_r, spos_r[FRAME_AW-1:PART_OW]};
    cmd.part_raddr = {s_r, spos_r[FRAME_AW-1:PART_OW]};
    cmd.part_wdata = rsp.part_rdata + PCNT_W'(1);
    case (state_r)
      S_CLEAR: begin
        cmd.seen_we = 1'b1;
        cmd.seen_waddr = {s_r, clr_r};
        cmd.seen_wdata = '0;
        cmd.part_we = (clr_r < ROW_IW'(PARTS_PER_SLOT));
        cmd.part_waddr = {s_r, clr_r[PART_IW-1:0]};
        cmd.part_wdata = '0;
      end
      S_STORE_RD: cmd.frame_we = 1'b1;
      S_STORE_WR: begin
        cmd.seen_we = !seen_bit;
        cmd.part_we = !seen_bit;
      end
      S_QUERY: cmd.part_raddr = {s_r, qk_r[PART_IW-1:0]};
      default: cmd.frame_we = 1'b0;
    endcase
  end

  fre_mem u_mem (
    .clk (clk),
    .cmd (cmd),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r <= '0;
      stored_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        hdr_r[k] <= '0;
      end
      for (int k = 0; k < NUM_SOURCES; k++) begin
        act_r[k] <= 1'b0;
        aseq_r[k] <= '0;
        atot_r[k] <= '0;
        rcv_r[k] <= '0;
        cval_r[k] <= 1'b0;
        cseq_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            s_r <= in_src;
            eop_r <= in_tlast;
            byte_r <= in_byte;
            q_r <= in_q;
            clr_r <= '0;
            qk_r <= '0;
            qd_r <= 1'b0;
            mask_r <= '0;
            case (in_mode)
              MODE_BYTE: begin
                spos_r <= st_pos;
                if (pos_r != POS_MAX) begin
                  pos_r <= pos_r + POS_W'(1);
                end
                if (is_hdr) begin
                  hdr_r[pos_r[3:2]][pos_r[1:0]*8 +: 8] <= in_byte;
                end
                if (!is_hdr && do_store && new_frame) begin
                  act_r[in_src] <= 1'b1;
                  aseq_r[in_src] <= h_seq;
                  atot_r[in_src] <= h_tot[CNT_W-1:0];
                  rcv_r[in_src] <= '0;
                end
              end
              MODE_RESET: act_r[in_src] <= 1'b0;
              MODE_QUERY: begin
                if (cmp_done || !act_hit) begin
                  out_valid_r <= 1'b1;
                  o_kind_r <= RK_ACK;
                  o_seq_r <= in_q;
                  o_tot_r <= '0;
                  o_rcv_r <= '0;
                  o_known_r <= cmp_done;
                  o_comp_r <= cmp_done;
                  o_mask_r <= '0;
                  o_rd_r <= '0;
                end
              end
              MODE_READ: spos_r <= in_addr;
              default: pos_r <= pos_r;
            endcase
          end
        end
        S_CLEAR: clr_r <= clr_r + ROW_IW'(1);
        S_STORE_WR: begin
          stored_r <= 1'b1;
          if (!seen_bit) begin
            rcv_r[s_r] <= rcv_r[s_r] + CNT_W'(1);
          end
        end
        S_REPORT: begin
          out_valid_r <= 1'b1;
          o_known_r <= 1'b0;
          o_comp_r <= 1'b0;
          o_mask_r <= '0;
          o_rd_r <= '0;
          if (!stored_r) begin
            o_kind_r <= RK_DROPPED;
            o_seq_r <= '0;
            o_tot_r <= '0;
            o_rcv_r <= '0;
          end else begin
            o_kind_r <= rep_done ? RK_COMPLETED : RK_STORED;
            o_seq_r <= aseq_r[s_r];
            o_tot_r <= atot_r[s_r];
            o_rcv_r <= rcv_r[s_r];
            if (rep_done) begin
              cval_r[s_r] <= 1'b1;
              cseq_r[s_r] <= aseq_r[s_r];
              act_r[s_r] <= 1'b0;
            end
          end
          pos_r <= '0;
          stored_r <= 1'b0;
          for (int k = 0; k < 4; k++) begin
            hdr_r[k] <= '0;
          end
        end
        S_QUERY: begin
          if (!qk_r[PART_IW]) begin
            qk_r <= qk_r + (PART_IW+1)'(1);
          end
          qd_r <= !qk_r[PART_IW];
          qi_r <= qk_r[PART_IW-1:0];
          mask_r <= mask_nxt;
          if (qd_r && qi_r == '1) begin
            out_valid_r <= 1'b1;
            o_kind_r <= RK_ACK;
            o_seq_r <= q_r;
            o_tot_r <= q_tot;
            o_rcv_r <= rcv_r[s_r];
            o_known_r <= 1'b1;
            o_comp_r <= (mask_nxt == '0) && (rcv_r[s_r] >= q_tot);
            o_mask_r <= mask_nxt;
            o_rd_r <= '0;
          end
        end
        S_READ_OUT: begin
          out_valid_r <= 1'b1;
          o_kind_r <= RK_READ;
          o_seq_r <= '0;
          o_tot_r <= '0;
          o_rcv_r <= '0;
          o_known_r <= 1'b0;
          o_comp_r <= 1'b0;
          o_mask_r <= '0;
          o_rd_r <= rsp.frame_rdata;
        end
        default: stored_r <= stored_r;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_kind_r;
  assign out_tdata  = {4'd0, o_rd_r, o_mask_r, o_comp_r, o_known_r, o_rcv_r, o_tot_r, o_seq_r};

  `FRE_ASSERT_NEVER(a_no_take_with_result, in_tready && out_valid_r, "input taken with result pending")
  `FRE_ASSERT(a_clear_to_store, (state_r == S_CLEAR && clr_r == '1) |=> (state_r == S_STORE_RD), "clear sweep did not end in store")
  `FRE_ASSERT(a_query_no_result, (state_r == S_QUERY) |-> !out_valid_r, "result pending during query sweep")
  `FRE_ASSERT(a_store_rmw, (state_r == S_STORE_RD) |=> (state_r == S_STORE_WR), "store read not followed by write")

endmodule
